/* sv/qrs_pkg.sv */
package qrs_pkg;

  localparam int CW   = 32;           // coefficient and root width
  localparam int FB   = 16;           // fraction bits
  localparam int PW   = 2 * CW;       // product width
  localparam int DW   = PW + 1;       // discriminant magnitude width
  localparam int RADW = DW + 1;       // radicand width, padded to even
  localparam int SQW  = RADW / 2;     // square root width
  localparam int RMW  = SQW + 4;      // square root remainder width
  localparam int NMW  = SQW + 1;      // numerator magnitude width
  localparam int DVW  = CW + 1;       // divisor width
  localparam int QW   = NMW + FB;     // quotient width before rounding
  localparam int NSW  = NMW + 1;      // signed numerator width

  localparam logic [2:0] ST_TRUE    = 3'd0;
  localparam logic [2:0] ST_FALSE   = 3'd1;
  localparam logic [2:0] ST_LINEAR  = 3'd2;
  localparam logic [2:0] ST_TWO     = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;
  localparam logic [2:0] ST_COMPLEX = 3'd5;
  localparam logic [2:0] ST_DEGEN   = 3'd6;

  localparam logic [1:0] DEG_CONST = 2'd0;
  localparam logic [1:0] DEG_LIN   = 2'd1;
  localparam logic [1:0] DEG_QUAD  = 2'd2;

  typedef struct packed {
    logic [1:0]    deg;
    logic [CW-1:0] am;
    logic          an;
    logic [CW-1:0] bm;
    logic          bn;
    logic [CW-1:0] cm;
    logic          cn;
    logic          dneg;
    logic          dzero;
  } ctl_t;

  typedef struct packed {
    logic [2:0] status;
  } tag_t;

endpackage

/* sv/quadratic_root_solver_unit.sv */
// quadratic root solver, fully pipelined
// request channel: coef_a_i, coef_b_i, coef_c_i (signed Q16.16) and degree_i
//   are taken at a rising edge where start_i is high and busy_o is low;
//   busy_o is held low, so a new request can be issued every cycle
// result channel: done_o is high for exactly one cycle, and status_o,
//   root_first_o, root_second_o and saturated_o are valid in that cycle only
// every degree passes through the same pipeline stages, and throughput is
//   one request per cycle
// most of the pipeline lies in the square root pipeline (one root bit per
//   stage, 33 stages) followed by the division pipeline (one quotient bit per
//   stage, 50 stages, plus a rounding stage)
// reset clears every valid bit, so no stale result is strobed after reset;
//   payload registers are not reset
// the receiver cannot stall: results leave on the strobe, and the pipeline
//   keeps advancing every cycle
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [CW-1:0] coef_a_i,
  input  logic [CW-1:0] coef_b_i,
  input  logic [CW-1:0] coef_c_i,
  input  logic [1:0]    degree_i,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic [CW-1:0] root_first_o,
  output logic [CW-1:0] root_second_o,
  output logic          saturated_o
);

  assign busy_o = 1'b0;

  // stage 1: sign and magnitude of each coefficient
  logic          s1_vld_q;
  ctl_t          s1_ctl_q;
  ctl_t          s1_ctl_d;

  always_comb begin
    s1_ctl_d       = '0;
    s1_ctl_d.deg   = degree_i;
    s1_ctl_d.an    = coef_a_i[CW-1];
    s1_ctl_d.am    = coef_a_i[CW-1] ? (~coef_a_i + 1'b1) : coef_a_i;
    s1_ctl_d.bn    = coef_b_i[CW-1];
    s1_ctl_d.bm    = coef_b_i[CW-1] ? (~coef_b_i + 1'b1) : coef_b_i;
    s1_ctl_d.cn    = coef_c_i[CW-1];
    s1_ctl_d.cm    = coef_c_i[CW-1] ? (~coef_c_i + 1'b1) : coef_c_i;
  end

  // stage 2: b*b and a*c
  logic          s2_vld_q;
  ctl_t          s2_ctl_q;
  logic [PW-1:0] s2_bb_q;
  logic [PW-1:0] s2_ac_q;

  // stage 3: discriminant magnitude and sign
  logic          s3_vld_q;
  ctl_t          s3_ctl_q;
  ctl_t          s3_ctl_d;
  logic [DW-1:0] s3_d_q;
  logic [DW-1:0] s3_d_d;
  logic [DW-1:0] p4;
  logic [DW-1:0] bbx;

  // a*c never exceeds 2^62, so its top bit is always clear
  assign p4  = {s2_ac_q[PW-2:0], 2'b00};
  assign bbx = {1'b0, s2_bb_q};

  always_comb begin
    s3_ctl_d      = s2_ctl_q;
    s3_ctl_d.dneg = 1'b0;
    if (s2_ac_q == '0) begin
      s3_d_d = bbx;
    end else if (s2_ctl_q.an != s2_ctl_q.cn) begin
      s3_d_d = bbx + p4;
    end else if (bbx >= p4) begin
      s3_d_d = bbx - p4;
    end else begin
      s3_d_d        = p4 - bbx;
      s3_ctl_d.dneg = 1'b1;
    end
    s3_ctl_d.dzero = (s3_d_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctl_q <= s1_ctl_d;
    s2_ctl_q <= s1_ctl_q;
    s2_bb_q  <= s1_ctl_q.bm * s1_ctl_q.bm;
    s2_ac_q  <= s1_ctl_q.am * s1_ctl_q.cm;
    s3_ctl_q <= s3_ctl_d;
    s3_d_q   <= s3_d_d;
  end

  // integer square root of the discriminant magnitude
  logic           sq_vld;
  logic [SQW-1:0] sq_root;
  ctl_t           sq_ctl;

  qrs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s3_vld_q),
    .in_rad_i   ({1'b0, s3_d_q}),
    .in_ctl_i   (s3_ctl_q),
    .out_vld_o  (sq_vld),
    .out_root_o (sq_root),
    .out_ctl_o  (sq_ctl)
  );

  // stage 4: status and the two division requests
  logic           pr_vld_q;
  tag_t           pr_tag_q;
  logic           pa_nneg_q, pa_dneg_q, pb_nneg_q, pb_dneg_q;
  logic [NMW-1:0] pa_nmag_q, pb_nmag_q;
  logic [DVW-1:0] pa_dmag_q, pb_dmag_q;

  tag_t           pr_tag_d;
  logic           pa_nneg_d, pa_dneg_d, pb_nneg_d, pb_dneg_d;
  logic [NMW-1:0] pa_nmag_d, pb_nmag_d;
  logic [DVW-1:0] pa_dmag_d, pb_dmag_d;
  logic [NSW-1:0] nb, rsum, rdif, nsel_a;
  logic [DVW-1:0] twoa;

  assign twoa = {sq_ctl.am, 1'b0};
  assign nb   = sq_ctl.bn ? {{(NSW-CW){1'b0}}, sq_ctl.bm}
                          : (~{{(NSW-CW){1'b0}}, sq_ctl.bm} + 1'b1);
  assign rsum = nb + {{(NSW-SQW){1'b0}}, sq_root};
  assign rdif = nb - {{(NSW-SQW){1'b0}}, sq_root};

  always_comb begin
    pr_tag_d.status = ST_DEGEN;
    pa_nneg_d = 1'b0;
    pa_nmag_d = '0;
    pa_dneg_d = 1'b0;
    pa_dmag_d = {{(DVW-1){1'b0}}, 1'b1};
    pb_nneg_d = 1'b0;
    pb_nmag_d = '0;
    pb_dneg_d = 1'b0;
    pb_dmag_d = {{(DVW-1){1'b0}}, 1'b1};
    nsel_a    = nb;
    unique case (sq_ctl.deg)
      DEG_CONST: begin
        pr_tag_d.status = (sq_ctl.cm == '0) ? ST_TRUE : ST_FALSE;
      end
      DEG_LIN: begin
        if (sq_ctl.bm != '0) begin
          pr_tag_d.status = ST_LINEAR;
          pa_nneg_d = !sq_ctl.cn;
          pa_nmag_d = {{(NMW-CW){1'b0}}, sq_ctl.cm};
          pa_dneg_d = sq_ctl.bn;
          pa_dmag_d = {1'b0, sq_ctl.bm};
        end
      end
      DEG_QUAD: begin
        if (sq_ctl.am != '0) begin
          if (sq_ctl.dneg) begin
            pr_tag_d.status = ST_COMPLEX;
            pb_nmag_d = {{(NMW-SQW){1'b0}}, sq_root};
            pb_dmag_d = twoa;
          end else if (sq_ctl.dzero) begin
            pr_tag_d.status = ST_DOUBLE;
          end else begin
            pr_tag_d.status = ST_TWO;
            nsel_a    = rsum;
            pb_nneg_d = rdif[NSW-1];
            pb_nmag_d = rdif[NSW-1] ? (~rdif[NMW-1:0] + 1'b1) : rdif[NMW-1:0];
            pb_dneg_d = sq_ctl.an;
            pb_dmag_d = twoa;
          end
          pa_nneg_d = nsel_a[NSW-1];
          pa_nmag_d = nsel_a[NSW-1] ? (~nsel_a[NMW-1:0] + 1'b1) : nsel_a[NMW-1:0];
          pa_dneg_d = sq_ctl.an;
          pa_dmag_d = twoa;
        end
      end
      default: begin
        pr_tag_d.status = ST_DEGEN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else begin
      pr_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_tag_q  <= pr_tag_d;
    pa_nneg_q <= pa_nneg_d;
    pa_nmag_q <= pa_nmag_d;
    pa_dneg_q <= pa_dneg_d;
    pa_dmag_q <= pa_dmag_d;
    pb_nneg_q <= pb_nneg_d;
    pb_nmag_q <= pb_nmag_d;
    pb_dneg_q <= pb_dneg_d;
    pb_dmag_q <= pb_dmag_d;
  end

  // two division lanes run in lockstep
  logic          da_vld, db_vld, da_sat, db_sat;
  tag_t          da_tag, db_tag;
  logic [CW-1:0] da_res, db_res;

  qrs_div u_div_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (pr_vld_q),
    .in_tag_i  (pr_tag_q),
    .in_nneg_i (pa_nneg_q),
    .in_nmag_i (pa_nmag_q),
    .in_dneg_i (pa_dneg_q),
    .in_dmag_i (pa_dmag_q),
    .out_vld_o (da_vld),
    .out_tag_o (da_tag),
    .out_res_o (da_res),
    .out_sat_o (da_sat)
  );

  qrs_div u_div_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (pr_vld_q),
    .in_tag_i  (pr_tag_q),
    .in_nneg_i (pb_nneg_q),
    .in_nmag_i (pb_nmag_q),
    .in_dneg_i (pb_dneg_q),
    .in_dmag_i (pb_dmag_q),
    .out_vld_o (db_vld),
    .out_tag_o (db_tag),
    .out_res_o (db_res),
    .out_sat_o (db_sat)
  );

  // output register: pick roots per status, zero where no root exists
  logic          use_a, use_b, dbl;
  logic          out_vld_q;
  logic [2:0]    out_st_q;
  logic [CW-1:0] out_r1_q, out_r2_q;
  logic          out_sat_q;

  assign dbl   = da_tag.status == ST_DOUBLE;
  assign use_b = (da_tag.status == ST_TWO) || (da_tag.status == ST_COMPLEX);
  assign use_a = use_b || dbl || (da_tag.status == ST_LINEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= da_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q  <= da_tag.status;
    out_r1_q  <= use_a ? da_res : '0;
    out_r2_q  <= use_b ? db_res : (dbl ? da_res : '0);
    out_sat_q <= (use_a && da_sat) || (use_b && db_sat);
  end

  assign done_o        = out_vld_q;
  assign status_o      = out_st_q;
  assign root_first_o  = out_r1_q;
  assign root_second_o = out_r2_q;
  assign saturated_o   = out_sat_q;

`ifndef SYNTHESIS
  // both division lanes carry the same request in the same cycle
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (da_vld == db_vld) && (!da_vld || (da_tag == db_tag)))
    else $error("division lanes out of step");

  // saturation only arises where a division result is reported
  a_sat_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> (status_o == ST_LINEAR) || (status_o == ST_TWO) ||
                              (status_o == ST_DOUBLE) || (status_o == ST_COMPLEX))
    else $error("saturation flagged without a root");

  // no-root results carry zero roots
  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((status_o == ST_TRUE) || (status_o == ST_FALSE) ||
               (status_o == ST_DEGEN)) |-> (root_first_o == '0) && (root_second_o == '0))
    else $error("nonzero root on a no-root result");

  // a double root reports the same value twice
  a_double_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_DOUBLE) |-> root_first_o == root_second_o)
    else $error("double root fields differ");
`endif

endmodule

/* sv/qrs_sqrt.sv */
module qrs_sqrt import qrs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  logic [RADW-1:0] in_rad_i,
  input  ctl_t            in_ctl_i,
  output logic            out_vld_o,
  output logic [SQW-1:0]  out_root_o,
  output ctl_t            out_ctl_o
);

  logic            vld_q  [SQW];
  logic [RADW-1:0] rad_q  [SQW];
  logic [RMW-1:0]  rem_q  [SQW];
  logic [SQW-1:0]  root_q [SQW];
  ctl_t            ctl_q  [SQW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < SQW; i++) begin : g_stage
    logic            vld_in;
    logic [RADW-1:0] rad_in;
    logic [RMW-1:0]  rem_in;
    logic [SQW-1:0]  root_in;
    ctl_t            ctl_in;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld_i;
      assign rad_in  = in_rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ctl_in  = in_ctl_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign ctl_in  = ctl_q[i-1];
    end

    assign rem_sh = {rem_in[RMW-3:0], rad_in[RADW-1:RADW-2]};
    assign trial  = {{(RMW-SQW-2){1'b0}}, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= {rad_in[RADW-3:0], 2'b00};
      rem_q[i]  <= ge ? rem_sh - trial : rem_sh;
      root_q[i] <= {root_in[SQW-2:0], ge};
      ctl_q[i]  <= ctl_in;
    end
  end

  assign out_vld_o  = vld_q[SQW-1];
  assign out_root_o = root_q[SQW-1];
  assign out_ctl_o  = ctl_q[SQW-1];

endmodule

/* sv/qrs_div.sv */
module qrs_div import qrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_vld_i,
  input  tag_t           in_tag_i,
  input  logic           in_nneg_i,
  input  logic [NMW-1:0] in_nmag_i,
  input  logic           in_dneg_i,
  input  logic [DVW-1:0] in_dmag_i,
  output logic           out_vld_o,
  output tag_t           out_tag_o,
  output logic [CW-1:0]  out_res_o,
  output logic           out_sat_o
);

  logic           vld_q [QW];
  tag_t           tag_q [QW];
  logic           sgn_q [QW];
  logic [QW-1:0]  num_q [QW];
  logic [DVW-1:0] den_q [QW];
  logic [DVW-1:0] rem_q [QW];
  logic [QW-1:0]  quo_q [QW];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic           vld_in;
    tag_t           tag_in;
    logic           sgn_in;
    logic [QW-1:0]  num_in;
    logic [DVW-1:0] den_in;
    logic [DVW-1:0] rem_in;
    logic [QW-1:0]  quo_in;
    logic [DVW:0]   rs;
    logic [DVW:0]   diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign vld_in = in_vld_i;
      assign tag_in = in_tag_i;
      assign sgn_in = in_nneg_i ^ in_dneg_i;
      assign num_in = {in_nmag_i, {FB{1'b0}}};
      assign den_in = in_dmag_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign tag_in = tag_q[i-1];
      assign sgn_in = sgn_q[i-1];
      assign num_in = num_q[i-1];
      assign den_in = den_q[i-1];
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign rs   = {rem_in, num_in[QW-1]};
    assign diff = rs - {1'b0, den_in};
    assign ge   = rs >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[i] <= tag_in;
      sgn_q[i] <= sgn_in;
      num_q[i] <= {num_in[QW-2:0], 1'b0};
      den_q[i] <= den_in;
      rem_q[i] <= ge ? diff[DVW-1:0] : rs[DVW-1:0];
      quo_q[i] <= {quo_in[QW-2:0], ge};
    end
  end

  // round half away from zero, then clip to the root range
  logic [QW:0]   qr;
  logic          rnd;
  logic          neg;
  logic [QW:0]   lim;
  logic          sat;
  logic [CW-1:0] mag;
  logic          vld_q_f;
  tag_t          tag_q_f;
  logic [CW-1:0] res_q;
  logic          sat_q;

  assign rnd = {rem_q[QW-1], 1'b0} >= {1'b0, den_q[QW-1]};
  assign qr  = {1'b0, quo_q[QW-1]} + {{QW{1'b0}}, rnd};
  assign neg = sgn_q[QW-1] && (qr != '0);
  assign lim = neg ? {{(QW-CW+1){1'b0}}, 1'b1, {(CW-1){1'b0}}}
                   : {{(QW-CW+2){1'b0}}, {(CW-1){1'b1}}};
  assign sat = qr > lim;
  assign mag = sat ? lim[CW-1:0] : qr[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q_f <= 1'b0;
    end else begin
      vld_q_f <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q_f <= tag_q[QW-1];
    res_q   <= neg ? (~mag + 1'b1) : mag;
    sat_q   <= sat;
  end

  assign out_vld_o = vld_q_f;
  assign out_tag_o = tag_q_f;
  assign out_res_o = res_q;
  assign out_sat_o = sat_q;

endmodule
